/* hdl/u8d_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned CpW = 21;
	localparam int unsigned StatW = 2;
	localparam int unsigned PendDepth = 3;
	localparam int unsigned CntW = 2;

	localparam logic [CpW-1:0] CpReplace = 21'h00FFFD;
	localparam logic [CpW-1:0] CpMax = 21'h10FFFF;
	localparam logic [CpW-1:0] CpSurLo = 21'h00D800;
	localparam logic [CpW-1:0] CpSurHi = 21'h00DFFF;
	localparam logic [CpW-1:0] CpMin4 = 21'h010000;
	localparam logic [CpW-1:0] CpMin3 = 21'h000800;
	localparam logic [CpW-1:0] CpMin2 = 21'h000080;

	typedef enum logic [StatW-1:0] {
		ST_VALID = 2'd0,
		ST_REPLACED = 2'd1,
		ST_MALFORMED = 2'd2,
		ST_END = 2'd3
	} status_t;

	// what the decoder does with one word
	typedef struct packed {
		logic emit;
		logic [CpW-1:0] cp;
		status_t status;
		logic clear;
	} dec_res_t;

	function automatic logic is_cont(input logic [ByteW-1:0] b);
		return b[7:6] == 2'b10;
	endfunction

endpackage

`default_nettype wire

/* hdl/utf8_byte_stream_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel  handshake            payload
// in       in_valid/in_stall    data_byte[7:0], end_of_stream
// out      out_valid/out_stall  code_point[20:0], status[1:0]
//
// One word accepted per cycle while in_stall is low; a result is decoded from the
// input register into the result register once its last byte is taken.
// Reset clears the valid flags and the pending count; pending bytes are
// not reset. A stalled result holds; words that give no result still drain
// while the output waits.

module utf8_byte_stream_decoder
	import u8d_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output      logic             in_stall,
	input  wire logic [ByteW-1:0] data_byte,
	input  wire logic             end_of_stream,
	output      logic             out_valid,
	input  wire logic             out_stall,
	output      logic [CpW-1:0]   code_point,
	output      logic [StatW-1:0] status
);

	logic             vld_s1;
	logic [ByteW-1:0] byte_s1;
	logic             eos_s1;
	logic [CntW-1:0]  cnt_q;
	logic [ByteW-1:0] pend_q [PendDepth];
	logic             out_vld_q;
	logic [CpW-1:0]   cp_q;
	status_t          stat_q;
	dec_res_t         dec;
	logic             adv;

	u8d_decode u_dec (
		.data_byte     (byte_s1),
		.end_of_stream (eos_s1),
		.pend_cnt      (cnt_q),
		.pend0         (pend_q[0]),
		.pend1         (pend_q[1]),
		.pend2         (pend_q[2]),
		.res           (dec)
	);

	assign adv = vld_s1 && (!dec.emit || !out_vld_q || !out_stall);
	assign in_stall = vld_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			eos_s1 <= end_of_stream;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (adv) begin
			if (dec.clear) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && !dec.clear) begin
			pend_q[cnt_q] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv && dec.emit) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && dec.emit) begin
			cp_q <= dec.cp;
			stat_q <= dec.status;
		end
	end

	assign out_valid = out_vld_q;
	assign code_point = cp_q;
	assign status = stat_q;

endmodule

`default_nettype wire

/* hdl/u8d_decode.sv */
`timescale 1ns / 1ps
`default_nettype none

module u8d_decode
	import u8d_pkg::*;
(
	input  wire logic [ByteW-1:0] data_byte,
	input  wire logic             end_of_stream,
	input  wire logic [CntW-1:0]  pend_cnt,
	input  wire logic [ByteW-1:0] pend0,
	input  wire logic [ByteW-1:0] pend1,
	input  wire logic [ByteW-1:0] pend2,
	output dec_res_t              res
);

	logic [ByteW-1:0] s0, s1, s2;
	logic [10:0] cp2;
	logic [15:0] cp3;
	logic [CpW-1:0] cp2x, cp3x, cp4;
	logic m2, m3, m4;

	// new byte sits at position pend_cnt
	assign s0 = (pend_cnt == 2'd0) ? data_byte : pend0;
	assign s1 = (pend_cnt == 2'd1) ? data_byte : pend1;
	assign s2 = (pend_cnt == 2'd2) ? data_byte : pend2;

	assign cp2 = {s0[4:0], s1[5:0]};
	assign cp3 = {s0[3:0], s1[5:0], s2[5:0]};
	assign cp4 = {pend0[2:0], pend1[5:0], pend2[5:0], data_byte[5:0]};
	assign cp2x = {10'd0, cp2};
	assign cp3x = {5'd0, cp3};

	assign m2 = (s0[7:5] == 3'b110) && is_cont(s1);
	assign m3 = (s0[7:4] == 4'b1110) && is_cont(s1) && is_cont(s2);
	assign m4 = (pend0[7:3] == 5'b11110) && is_cont(pend1) && is_cont(pend2)
		&& is_cont(data_byte);

	always_comb begin
		res.emit = 1'b0;
		res.cp = '0;
		res.status = ST_VALID;
		res.clear = 1'b0;
		if (end_of_stream) begin
			res.emit = 1'b1;
			res.status = ST_END;
			res.clear = 1'b1;
		end else begin
			case (pend_cnt)
				2'd0: begin
					if (!s0[7]) begin
						res.emit = 1'b1;
						res.cp = {13'd0, s0};
						res.clear = 1'b1;
					end
				end
				2'd1: begin
					if (m2) begin
						res.emit = 1'b1;
						res.clear = 1'b1;
						if (cp2x < CpMin2) begin
							res.cp = CpReplace;
							res.status = ST_REPLACED;
						end else begin
							res.cp = cp2x;
						end
					end
				end
				2'd2: begin
					if (m3) begin
						res.emit = 1'b1;
						res.clear = 1'b1;
						if (cp3x < CpMin3 || (cp3x >= CpSurLo && cp3x <= CpSurHi)) begin
							res.cp = CpReplace;
							res.status = ST_REPLACED;
						end else begin
							res.cp = cp3x;
						end
					end
				end
				default: begin
					res.emit = 1'b1;
					res.clear = 1'b1;
					if (m4) begin
						if (cp4 < CpMin4 || cp4 > CpMax) begin
							res.cp = CpReplace;
							res.status = ST_REPLACED;
						end else begin
							res.cp = cp4;
						end
					end else begin
						res.status = ST_MALFORMED;
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* hdl/u8d_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module u8d_checker
	import u8d_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_stall,
	input wire logic             out_valid,
	input wire logic             out_stall,
	input wire logic [CpW-1:0]   code_point,
	input wire logic [StatW-1:0] status
);

	ap_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(code_point) && $stable(status))
		else $error("stalled result changed");

	ap_zero_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_END || status == ST_MALFORMED) |-> code_point == '0)
		else $error("end or malformed word with nonzero code point");

	ap_replace: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_REPLACED |-> code_point == CpReplace)
		else $error("replaced word without U+FFFD");

	ap_scalar: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_VALID |->
		code_point <= CpMax && (code_point < CpSurLo || code_point > CpSurHi))
		else $error("valid word is not a scalar value");

	// a word sitting in the input register with a free output is never stalled
	ap_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |-> out_valid && out_stall)
		else $error("input stalled while output is free");

endmodule

bind utf8_byte_stream_decoder u8d_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.code_point (code_point),
	.status     (status)
);

`default_nettype wire
